// File: rtl/core/arf_pkg.sv
// ----------------------------------------------------------------------------
// arf_pkg
// Shared types for the ALU / register file / NZCV flags block.
// ----------------------------------------------------------------------------
package arf_pkg;

	localparam int REG_IDX_W = 3;
	localparam int IMM_W     = 32;
	localparam int RESULT_W  = 32;

	typedef enum logic [1:0] {
		KIND_MOV = 2'd0,
		KIND_RRR = 2'd1,
		KIND_RRI = 2'd2,
		KIND_CMP = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_XOR = 3'd2,
		OP_LSL = 3'd3,
		OP_ASR = 3'd4,
		OP_LSR = 3'd5,
		OP_OR  = 3'd6,
		OP_AND = 3'd7
	} op_t;

	// carry / overflow pair produced by the ALU
	typedef struct packed {
		logic c;
		logic v;
	} cv_t;

	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} flags_t;

endpackage

// File: rtl/core/arf_regfile.sv
// ----------------------------------------------------------------------------
// arf_regfile
// Register file memory: two synchronous read ports, one write port,
// per-entry valid bits for reset-to-zero, write-to-read forwarding.
// ----------------------------------------------------------------------------
module arf_regfile #(
	parameter int REGISTER_COUNT = 8,
	parameter int DATA_WIDTH     = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [arf_pkg::REG_IDX_W-1:0]  rd_addr_a,
	input  logic [arf_pkg::REG_IDX_W-1:0]  rd_addr_b,
	input  logic                           wr_en,
	input  logic [arf_pkg::REG_IDX_W-1:0]  wr_addr,
	input  logic [DATA_WIDTH-1:0]          wr_data,
	output logic [DATA_WIDTH-1:0]          rd_data_a,
	output logic [DATA_WIDTH-1:0]          rd_data_b
);

	localparam int AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
	localparam int EW = AW + arf_pkg::REG_IDX_W;
	localparam logic [EW-1:0] COUNT_EXT = EW'(REGISTER_COUNT);

	logic [DATA_WIDTH-1:0]     mem [REGISTER_COUNT];
	logic [REGISTER_COUNT-1:0] vld_q;

	logic [EW-1:0] ext_a, ext_b, ext_w;
	logic [AW-1:0] addr_a, addr_b, addr_w;
	logic          ok_a, ok_b, ok_w;
	logic          wr_go;
	logic          fwd_a, fwd_b;

	always_comb begin
		ext_a  = {{AW{1'b0}}, rd_addr_a};
		ext_b  = {{AW{1'b0}}, rd_addr_b};
		ext_w  = {{AW{1'b0}}, wr_addr};
		addr_a = ext_a[AW-1:0];
		addr_b = ext_b[AW-1:0];
		addr_w = ext_w[AW-1:0];
		ok_a   = ext_a < COUNT_EXT;
		ok_b   = ext_b < COUNT_EXT;
		ok_w   = ext_w < COUNT_EXT;
		wr_go  = wr_en && ok_w;
		// same-edge write wins over the stale array contents
		fwd_a  = wr_go && (rd_addr_a == wr_addr);
		fwd_b  = wr_go && (rd_addr_b == wr_addr);
	end

	always_ff @(posedge clk) begin
		if (wr_go) begin
			mem[addr_w] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_go) begin
			vld_q[addr_w] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (fwd_a) begin
				rd_data_a <= wr_data;
			end else if (ok_a && vld_q[addr_a]) begin
				rd_data_a <= mem[addr_a];
			end else begin
				rd_data_a <= '0;
			end
			if (fwd_b) begin
				rd_data_b <= wr_data;
			end else if (ok_b && vld_q[addr_b]) begin
				rd_data_b <= mem[addr_b];
			end else begin
				rd_data_b <= '0;
			end
		end
	end

endmodule

// File: rtl/core/arf_alu.sv
// ----------------------------------------------------------------------------
// arf_alu
// Add/sub/logic/shift datapath with ARM-style carry and overflow.
// ----------------------------------------------------------------------------
module arf_alu #(
	parameter int DATA_WIDTH = 32
) (
	input  arf_pkg::op_t            op,
	input  logic [DATA_WIDTH-1:0]   a,
	input  logic [DATA_WIDTH-1:0]   b,
	input  arf_pkg::cv_t            cv_in,
	output logic [DATA_WIDTH-1:0]   result,
	output arf_pkg::cv_t            cv_out
);

	localparam int W = DATA_WIDTH;

	logic [4:0] amt;
	logic [W:0] sum_w;
	logic [W:0] lsl_w;
	logic [W:0] lsr_w;
	logic [W:0] asr_w;
	logic [W-1:0] diff;

	always_comb begin
		amt   = b[4:0];
		sum_w = {1'b0, a} + {1'b0, b};
		diff  = a - b;
		// one extra bit catches the last bit shifted out
		lsl_w = {1'b0, a} << amt;
		lsr_w = {a, 1'b0} >> amt;
		asr_w = $signed({a, 1'b0}) >>> amt;

		result = '0;
		cv_out = cv_in;
		unique case (op)
			arf_pkg::OP_ADD: begin
				result   = sum_w[W-1:0];
				cv_out.c = sum_w[W];
				cv_out.v = (a[W-1] ~^ b[W-1]) && (sum_w[W-1] != a[W-1]);
			end
			arf_pkg::OP_SUB: begin
				result   = diff;
				cv_out.c = a >= b;
				cv_out.v = (a[W-1] != b[W-1]) && (diff[W-1] != a[W-1]);
			end
			arf_pkg::OP_XOR: result = a ^ b;
			arf_pkg::OP_LSL: begin
				result = lsl_w[W-1:0];
				if (amt != '0) cv_out.c = lsl_w[W];
			end
			arf_pkg::OP_ASR: begin
				result = asr_w[W:1];
				if (amt != '0) cv_out.c = asr_w[0];
			end
			arf_pkg::OP_LSR: begin
				result = lsr_w[W:1];
				if (amt != '0) cv_out.c = lsr_w[0];
			end
			arf_pkg::OP_OR:  result = a | b;
			arf_pkg::OP_AND: result = a & b;
			default: result = '0;
		endcase
	end

endmodule

// File: rtl/core/alu_register_file_nzcv.sv
// Executes one instruction per request against a register file of
// REGISTER_COUNT words and a set of NZCV flags. A request is taken every
// cycle unless the output stalls. At acceptance the source registers are read
// from a synchronous memory; in the next cycle the ALU runs, and when the
// request advances the destination is written back and the flags update. A
// write landing on the same edge as a dependent read is forwarded, so
// back-to-back dependent requests need no bubble. Registers read as zero
// after reset (per-entry valid bits, no clearing pass). The output register
// lets one finished result wait while the next request is already in flight.
// ----------------------------------------------------------------------------
// alu_register_file_nzcv
// Top level: request stage, register file, ALU, flags and output register.
// ----------------------------------------------------------------------------
module alu_register_file_nzcv #(
	parameter int REGISTER_COUNT = 8,
	parameter int DATA_WIDTH     = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          kind,
	input  logic [2:0]                          alu_op,
	input  logic                                set_flags,
	input  logic [arf_pkg::REG_IDX_W-1:0]       dest_reg,
	input  logic [arf_pkg::REG_IDX_W-1:0]       src_a_reg,
	input  logic [arf_pkg::REG_IDX_W-1:0]       src_b_reg,
	input  logic [arf_pkg::IMM_W-1:0]           immediate,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [arf_pkg::RESULT_W-1:0]        result_value,
	output logic                                flag_n,
	output logic                                flag_z,
	output logic                                flag_c,
	output logic                                flag_v
);

	localparam int DW = DATA_WIDTH;

	logic                               accept;
	logic                               adv;
	logic                               valid_s1;
	arf_pkg::kind_t                     kind_s1;
	arf_pkg::op_t                       op_s1;
	logic                               setf_s1;
	logic [arf_pkg::REG_IDX_W-1:0]      dest_s1;
	logic [DW-1:0]                      imm_s1;
	arf_pkg::flags_t                    flags_q;
	arf_pkg::flags_t                    flags_nxt;
	logic                               out_valid_q;

	logic [DW+arf_pkg::IMM_W-1:0]       imm_ext;
	logic [DW+arf_pkg::RESULT_W-1:0]    res_ext;
	logic [DW-1:0]                      rd_a, rd_b, b_op, alu_res, res;
	arf_pkg::cv_t                       cv_cur, cv_alu, cv_new;
	logic                               wr_en;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign accept   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign imm_ext  = {{DW{1'b0}}, immediate};

	arf_regfile #(
		.REGISTER_COUNT (REGISTER_COUNT),
		.DATA_WIDTH     (DATA_WIDTH)
	) u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (src_a_reg),
		.rd_addr_b (src_b_reg),
		.wr_en     (wr_en),
		.wr_addr   (dest_s1),
		.wr_data   (res),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	arf_alu #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_alu (
		.op     (op_s1),
		.a      (rd_a),
		.b      (b_op),
		.cv_in  (cv_cur),
		.result (alu_res),
		.cv_out (cv_alu)
	);

	always_comb begin
		cv_cur.c = flags_q.c;
		cv_cur.v = flags_q.v;
		b_op     = (kind_s1 == arf_pkg::KIND_RRI) ? imm_s1 : rd_b;
		if (kind_s1 == arf_pkg::KIND_MOV) begin
			res    = imm_s1;
			cv_new = cv_cur;
		end else begin
			res    = alu_res;
			cv_new = cv_alu;
		end
		if (setf_s1) begin
			flags_nxt.n = res[DW-1];
			flags_nxt.z = (res == '0);
			flags_nxt.c = cv_new.c;
			flags_nxt.v = cv_new.v;
		end else begin
			flags_nxt = flags_q;
		end
		wr_en   = adv && (kind_s1 != arf_pkg::KIND_CMP);
		res_ext = {{arf_pkg::RESULT_W{1'b0}}, res};
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			flags_q     <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				flags_q     <= flags_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= arf_pkg::kind_t'(kind);
			op_s1   <= arf_pkg::op_t'(alu_op);
			setf_s1 <= set_flags || (kind == arf_pkg::KIND_CMP);
			dest_s1 <= dest_reg;
			imm_s1  <= imm_ext[DW-1:0];
		end
		if (adv) begin
			result_value <= res_ext[arf_pkg::RESULT_W-1:0];
			flag_n       <= flags_nxt.n;
			flag_z       <= flags_nxt.z;
			flag_c       <= flags_nxt.c;
			flag_v       <= flags_nxt.v;
		end
	end

`ifndef NO_ASSERTIONS
	a_ready_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("in_ready low without a stalled request");

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("advanced request produced no result");

	a_flags_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv || !setf_s1) |=> $stable(flags_q))
		else $error("flags changed without a flag-setting request");

	a_flags_shown: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (flag_n == flags_q.n && flag_z == flags_q.z &&
			flag_c == flags_q.c && flag_v == flags_q.v))
		else $error("result flags differ from flag register");
`endif

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for alu_register_file_nzcv. A short table of
// instructions covers reset state, word extremes, every operation and the
// shift and flag corner cases; then random instructions run in bursts
// against a stalling receiver. Every result is checked against a local
// model of the register file and NZCV flags, or a table row's listed outcome.
// ----------------------------------------------------------------------------
module tb;
	import arf_pkg::*;

	localparam int RAND_ITEMS  = 1130;
	localparam int HOLD_CYCLES = 60;
	localparam int QUIET_LIMIT = 1000;
	localparam int DIR_ROWS    = 24;

	typedef struct packed {
		kind_t       kind;
		op_t         op;
		logic        setf;
		logic [2:0]  dst;
		logic [2:0]  src_a;
		logic [2:0]  src_b;
		logic [31:0] imm;
	} instr_t;

	typedef struct packed {
		logic [31:0] value;
		flags_t      flags;
	} outcome_t;

	// typed = 1: the listed value/flags are the expected outcome
	typedef struct packed {
		instr_t      ins;
		logic        typed;
		logic [31:0] val;
		flags_t      flg;
	} dir_row_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_COIN,
		RX_QUARTER,
		RX_MOSTLY
	} rx_mode_t;

	localparam logic [31:0] CORNER_IMM [8] = '{
		32'h0000_0000, 32'h0000_0001, 32'h0000_001F, 32'h0000_0020,
		32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFE0, 32'hFFFF_FFFF
	};

	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{'{KIND_RRR, OP_ADD, 1'b1, 3'd3, 3'd4, 3'd5, 32'h0}, 1'b1, 32'h0, 4'b0100},
		'{'{KIND_MOV, OP_AND, 1'b1, 3'd1, 3'd7, 3'd7, 32'hFFFF_FFFF}, 1'b1,
			32'hFFFF_FFFF, 4'b1000},
		'{'{KIND_MOV, OP_SUB, 1'b1, 3'd2, 3'd0, 3'd0, 32'h7FFF_FFFF}, 1'b1,
			32'h7FFF_FFFF, 4'b0000},
		'{'{KIND_MOV, OP_XOR, 1'b0, 3'd6, 3'd0, 3'd0, 32'h0}, 1'b1, 32'h0, 4'b0000},
		'{'{KIND_RRR, OP_ADD, 1'b1, 3'd3, 3'd1, 3'd1, 32'h0}, 1'b0, 32'h0, 4'b0000},
		'{'{KIND_RRI, OP_ADD, 1'b1, 3'd4, 3'd2, 3'd0, 32'h1}, 1'b1,
			32'h8000_0000, 4'b1001},
		'{'{KIND_RRR, OP_SUB, 1'b1, 3'd5, 3'd6, 3'd1, 32'h0}, 1'b0, 32'h0, 4'b0000},
		'{'{KIND_RRR, OP_SUB, 1'b1, 3'd0, 3'd1, 3'd1, 32'h0}, 1'b0, 32'h0, 4'b0000},
		'{'{KIND_CMP, OP_SUB, 1'b0, 3'd7, 3'd4, 3'd2, 32'h0}, 1'b0, 32'h0, 4'b0000},
		'{'{KIND_RRR, OP_ADD, 1'b0, 3'd7, 3'd1, 3'd2, 32'h0}, 1'b0, 32'h0, 4'b0000},
		'{'{KIND_RRR, OP_XOR, 1'b1, 3'd7, 3'd1, 3'd2, 32'h0}, 1'b0, 32'h0, 4'b0000},
		'{'{KIND_RRR, OP_OR,  1'b0, 3'd5, 3'd2, 3'd4, 32'h0}, 1'b0, 32'h0, 4'b0000},
		'{'{KIND_CMP, OP_AND, 1'b0, 3'd0, 3'd1, 3'd4, 32'h0}, 1'b0, 32'h0, 4'b0000},
		'{'{KIND_RRI, OP_LSL, 1'b1, 3'd3, 3'd1, 3'd0, 32'd1}, 1'b0, 32'h0, 4'b0000},
		'{'{KIND_RRI, OP_LSL, 1'b1, 3'd3, 3'd2, 3'd0, 32'd31}, 1'b0, 32'h0, 4'b0000},
		'{'{KIND_RRI, OP_LSL, 1'b1, 3'd3, 3'd1, 3'd0, 32'd32}, 1'b0, 32'h0, 4'b0000},
		'{'{KIND_RRI, OP_ASR, 1'b1, 3'd3, 3'd1, 3'd0, 32'd31}, 1'b0, 32'h0, 4'b0000},
		'{'{KIND_RRI, OP_ASR, 1'b1, 3'd3, 3'd4, 3'd0, 32'd4}, 1'b0, 32'h0, 4'b0000},
		'{'{KIND_RRI, OP_LSR, 1'b1, 3'd3, 3'd1, 3'd0, 32'd31}, 1'b0, 32'h0, 4'b0000},
		'{'{KIND_RRI, OP_LSR, 1'b1, 3'd3, 3'd2, 3'd0, 32'hFFFF_FFE0}, 1'b0,
			32'h0, 4'b0000},
		'{'{KIND_RRR, OP_LSR, 1'b1, 3'd6, 3'd1, 3'd5, 32'h0}, 1'b0, 32'h0, 4'b0000},
		'{'{KIND_RRI, OP_AND, 1'b1, 3'd7, 3'd7, 3'd0, 32'hFFFF_FFFF}, 1'b0,
			32'h0, 4'b0000},
		'{'{KIND_RRI, OP_XOR, 1'b0, 3'd7, 3'd7, 3'd0, 32'hFFFF_FFFF}, 1'b0,
			32'h0, 4'b0000},
		'{'{KIND_RRR, OP_ASR, 1'b1, 3'd0, 3'd4, 3'd1, 32'h0}, 1'b0, 32'h0, 4'b0000}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [2:0]  alu_op;
	logic        set_flags;
	logic [2:0]  dest_reg;
	logic [2:0]  src_a_reg;
	logic [2:0]  src_b_reg;
	logic [31:0] immediate;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] result_value;
	logic        flag_n;
	logic        flag_z;
	logic        flag_c;
	logic        flag_v;

	// model state
	logic [31:0] gpr [8];
	flags_t      nzcv;

	outcome_t    pending_results [$];
	int          mismatch_cnt;
	int          quiet_cycles;
	logic        hold_req;

	// typed expectation riding along with the request on the bus
	logic        cur_typed;
	logic [31:0] cur_val;
	flags_t      cur_flg;

	alu_register_file_nzcv uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.alu_op       (alu_op),
		.set_flags    (set_flags),
		.dest_reg     (dest_reg),
		.src_a_reg    (src_a_reg),
		.src_b_reg    (src_b_reg),
		.immediate    (immediate),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.flag_n       (flag_n),
		.flag_z       (flag_z),
		.flag_c       (flag_c),
		.flag_v       (flag_v)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// runs one instruction on the model state, returns value and new flags
	function automatic outcome_t exec_instr(instr_t ins);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] r;
		logic [32:0] sum;
		logic [4:0]  amt;
		logic        nc;
		logic        nv;
		outcome_t    res;
		nc = nzcv.c;
		nv = nzcv.v;
		a = gpr[ins.src_a];
		b = (ins.kind == KIND_RRI) ? ins.imm : gpr[ins.src_b];
		amt = b[4:0];
		if (ins.kind == KIND_MOV) begin
			r = ins.imm;
		end else begin
			case (ins.op)
				OP_ADD: begin
					sum = {1'b0, a} + {1'b0, b};
					r = sum[31:0];
					nc = sum[32];
					nv = (a[31] == b[31]) && (r[31] != a[31]);
				end
				OP_SUB: begin
					r = a - b;
					nc = (a >= b);
					nv = (a[31] != b[31]) && (r[31] != a[31]);
				end
				OP_XOR: r = a ^ b;
				OP_LSL: begin
					r = a << amt;
					// bit 32 - amt, taken modulo 32
					if (amt != 5'd0)
						nc = a[5'd0 - amt];
				end
				OP_ASR: begin
					r = $signed(a) >>> amt;
					if (amt != 5'd0)
						nc = a[amt - 5'd1];
				end
				OP_LSR: begin
					r = a >> amt;
					if (amt != 5'd0)
						nc = a[amt - 5'd1];
				end
				OP_OR:  r = a | b;
				default: r = a & b;
			endcase
		end
		if (ins.kind != KIND_CMP)
			gpr[ins.dst] = r;
		if (ins.setf || ins.kind == KIND_CMP)
			nzcv = '{r[31], r == 32'd0, nc, nv};
		res.value = r;
		res.flags = nzcv;
		return res;
	endfunction

	task automatic send_instr(input instr_t ins, input logic typed,
			input logic [31:0] val, input flags_t flg);
		kind      = ins.kind;
		alu_op    = ins.op;
		set_flags = ins.setf;
		dest_reg  = ins.dst;
		src_a_reg = ins.src_a;
		src_b_reg = ins.src_b;
		immediate = ins.imm;
		cur_typed = typed;
		cur_val   = val;
		cur_flg   = flg;
		in_valid  = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// request capture and result check in one place, so order within an edge is fixed
	always @(posedge clk) begin : track
		instr_t   acc;
		outcome_t want;
		outcome_t got;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				acc = '{kind_t'(kind), op_t'(alu_op), set_flags, dest_reg,
					src_a_reg, src_b_reg, immediate};
				want = exec_instr(acc);
				if (cur_typed)
					want = '{cur_val, cur_flg};
				pending_results.push_back(want);
			end
			if (out_valid && out_ready) begin
				got = '{result_value, '{flag_n, flag_z, flag_c, flag_v}};
				if (pending_results.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("%0t: result %h nzcv %b with nothing expected",
							$realtime, got.value, got.flags);
					mismatch_cnt++;
				end else begin
					want = pending_results.pop_front();
					if (got.value !== want.value || got.flags.n !== want.flags.n ||
							got.flags.z !== want.flags.z || got.flags.c !== want.flags.c ||
							got.flags.v !== want.flags.v) begin
						if (mismatch_cnt < 10)
							$display("%0t: expected %h nzcv %b, got %h nzcv %b",
								$realtime, want.value, want.flags, got.value, got.flags);
						mismatch_cnt++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// receiver: changing stall patterns, plus a long hold on request
	initial begin : receiver
		rx_mode_t rx_mode;
		int       rx_cycle;
		out_ready = 1'b0;
		rx_mode = RX_FREE;
		rx_cycle = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES - 1)
					@(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (rx_cycle % 97 == 0)
					rx_mode = rx_mode_t'($urandom_range(0, 3));
				case (rx_mode)
					RX_FREE:    out_ready = 1'b1;
					RX_COIN:    out_ready = 1'($urandom_range(0, 1));
					RX_QUARTER: out_ready = (rx_cycle % 4 == 0);
					default:    out_ready = ($urandom_range(0, 7) != 0);
				endcase
				rx_cycle++;
			end
		end
	end

	initial begin : watchdog
		@(posedge arst_n);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		instr_t rq;
		int     burst;
		int     sent;
		int     pick;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		kind      = '0;
		alu_op    = '0;
		set_flags = 1'b0;
		dest_reg  = '0;
		src_a_reg = '0;
		src_b_reg = '0;
		immediate = '0;
		cur_typed = 1'b0;
		cur_val   = '0;
		cur_flg   = '0;
		hold_req  = 1'b0;
		mismatch_cnt = 0;
		quiet_cycles = 0;
		nzcv = '0;
		for (int i = 0; i < 8; i++)
			gpr[i] = '0;
		repeat (11)
			@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_ROWS; i++)
			send_instr(DIRECTED[i].ins, DIRECTED[i].typed, DIRECTED[i].val,
				DIRECTED[i].flg);

		sent = 0;
		while (sent < RAND_ITEMS) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && sent < RAND_ITEMS; i++) begin
				if (sent == 300 || sent == 850)
					hold_req = 1'b1;
				if (sent == 600) begin
					// let everything in flight come out before going on
					in_valid = 1'b0;
					while (pending_results.size() != 0)
						@(negedge clk);
				end
				rq.kind  = kind_t'($urandom_range(0, 3));
				rq.op    = op_t'($urandom_range(0, 7));
				rq.setf  = 1'($urandom_range(0, 1));
				rq.dst   = 3'($urandom_range(0, 7));
				rq.src_a = 3'($urandom_range(0, 7));
				rq.src_b = 3'($urandom_range(0, 7));
				pick = $urandom_range(0, 7);
				if (pick == 0)
					rq.imm = $urandom_range(0, 40);
				else if (pick == 1)
					rq.imm = CORNER_IMM[3'($urandom_range(0, 7))];
				else
					rq.imm = $urandom;
				send_instr(rq, 1'b0, '0, '0);
				sent++;
			end
			if ($urandom_range(0, 3) != 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, 8))
					@(negedge clk);
			end
		end

		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (8)
			@(negedge clk);
		if (mismatch_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
